FILE: design/tpc_pkg.sv
// tpc_pkg: shared types and constants of the tftp packet checker
// used by tpc_parse, tftp_packet_checker_top and tpc_checker; no dependencies
package tpc_pkg;

  // size limits
  localparam int unsigned MAX_PACKET_BYTES = 516;
  localparam int unsigned COUNT_W          = 10;
  localparam int unsigned POS_W            = 4;
  localparam int unsigned MODE_CHARS       = 8;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_A_TEXT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_A_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_B_TEXT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_B_LEN  = 2'd3;

  // tftp opcodes
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // error codes of 8 and above are undefined
  localparam logic [15:0] ERR_CODE_LIMIT = 16'd8;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_BAD_MODE   = 3'd3,
    ST_BAD_ERROR  = 3'd4,
    ST_UNKNOWN_OP = 3'd5
  } status_e;

  // configured mode strings
  typedef struct packed {
    logic [CFG_DATA_W-1:0] text_a;
    logic [POS_W-1:0]      len_a;
    logic [CFG_DATA_W-1:0] text_b;
    logic [POS_W-1:0]      len_b;
  } mode_cfg_t;

endpackage

FILE: design/tftp_packet_checker_top.sv
// Tftp packet checker: takes one packet byte per word with a last flag and
// returns one status word and the opcode when the last byte has been taken.
// Depends on tpc_pkg and tpc_parse.
//
// A byte is taken every cycle while the result side keeps up; the last byte of
// a packet sits in the input register and its result in the result register,
// around the combinational state update. The user must write the mode strings
// through the cfg port only while no packet is in flight, which is not enforced.
module tftp_packet_checker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [15:0]                     opcode_o,
  input  logic                            cfg_we_i,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tpc_pkg::*;

  mode_cfg_t   cfg_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        out_valid_q;
  status_e     out_status_q;
  logic [15:0] out_opcode_q;
  logic        out_free, s1_adv, in_acc;
  status_e     status_d;
  logic [15:0] opcode_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE_A_TEXT: cfg_q.text_a <= cfg_data_i;
        CFG_MODE_A_LEN:  cfg_q.len_a  <= cfg_data_i[POS_W-1:0];
        CFG_MODE_B_TEXT: cfg_q.text_b <= cfg_data_i;
        CFG_MODE_B_LEN:  cfg_q.len_b  <= cfg_data_i[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: a non-last byte never waits on the result side
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (out_free || !s1_last_q);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // packet state and verdict
  tpc_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .cfg_i    (cfg_q),
    .status_o (status_d),
    .opcode_o (opcode_d)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_i;
    end
    if (s1_adv && s1_last_q) begin
      out_status_q <= status_d;
      out_opcode_q <= opcode_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign opcode_o    = out_opcode_q;

endmodule

FILE: design/tpc_parse.sv
// tpc_parse: per-packet state of the checker and the final verdict
// depends on tpc_pkg
module tpc_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  tpc_pkg::mode_cfg_t cfg_i,
  output tpc_pkg::status_e   status_o,
  output logic [15:0]        opcode_o
);
  import tpc_pkg::*;

  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_MODE = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
  localparam logic [COUNT_W-1:0] MAX_LEN   = COUNT_W'(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0]   MODE_LEN  = POS_W'(MODE_CHARS);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [15:0]        opcode_q, opcode_d;
  logic [15:0]        err_q, err_d;
  phase_e             phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               match_a_q, match_a_d;
  logic               match_b_q, match_b_d;
  logic [7:0]         char_a, char_b;
  logic               hit_a, hit_b;
  status_e            verdict;

  // mode characters at the current position
  assign char_a = cfg_i.text_a[{pos_q[2:0], 3'b000} +: 8];
  assign char_b = cfg_i.text_b[{pos_q[2:0], 3'b000} +: 8];
  assign hit_a  = (pos_q < MODE_LEN) && (pos_q < cfg_i.len_a) && (char_a == byte_i);
  assign hit_b  = (pos_q < MODE_LEN) && (pos_q < cfg_i.len_b) && (char_b == byte_i);

  // state update for one byte
  always_comb begin
    opcode_d  = opcode_q;
    err_d     = err_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    match_a_d = match_a_q;
    match_b_d = match_b_q;
    if (count_q < COUNT_W'(2)) begin
      opcode_d = {opcode_q[7:0], byte_i};
    end else begin
      if (count_q < COUNT_W'(4)) begin
        err_d = {err_q[7:0], byte_i};
      end
      unique case (phase_q)
        PH_NAME: begin
          if (byte_i == 8'd0) begin
            phase_d = PH_MODE;
            pos_d   = '0;
          end
        end
        PH_MODE: begin
          if (byte_i == 8'd0) begin
            if (pos_q != cfg_i.len_a || cfg_i.len_a > MODE_LEN) match_a_d = 1'b0;
            if (pos_q != cfg_i.len_b || cfg_i.len_b > MODE_LEN) match_b_d = 1'b0;
            phase_d = PH_DONE;
          end else begin
            if (!hit_a) match_a_d = 1'b0;
            if (!hit_b) match_b_d = 1'b0;
            if (pos_q != POS_MAX) pos_d = pos_q + POS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    count_d = (count_q != COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;
  end

  // verdict on the state after this byte
  always_comb begin
    priority if (count_d < COUNT_W'(2)) begin
      verdict = ST_TOO_SHORT;
    end else if (count_d > MAX_LEN) begin
      verdict = ST_TOO_LONG;
    end else if (opcode_d == OP_RRQ || opcode_d == OP_WRQ) begin
      priority if (count_d < COUNT_W'(4))        verdict = ST_TOO_SHORT;
      else if (phase_d != PH_DONE)               verdict = ST_BAD_MODE;
      else if (!match_a_d && !match_b_d)         verdict = ST_BAD_MODE;
      else                                       verdict = ST_OK;
    end else if (opcode_d == OP_DATA) begin
      verdict = (count_d < COUNT_W'(4)) ? ST_TOO_SHORT : ST_OK;
    end else if (opcode_d == OP_ACK) begin
      priority if (count_d < COUNT_W'(4))        verdict = ST_TOO_SHORT;
      else if (count_d > COUNT_W'(4))            verdict = ST_TOO_LONG;
      else                                       verdict = ST_OK;
    end else if (opcode_d == OP_ERROR) begin
      priority if (count_d < COUNT_W'(5))        verdict = ST_TOO_SHORT;
      else if (err_d >= ERR_CODE_LIMIT)          verdict = ST_BAD_ERROR;
      else                                       verdict = ST_OK;
    end else begin
      verdict = ST_UNKNOWN_OP;
    end
  end

  assign status_o = verdict;
  assign opcode_o = (count_d >= COUNT_W'(2)) ? opcode_d : 16'd0;

  // packet state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      opcode_q  <= '0;
      err_q     <= '0;
      phase_q   <= PH_NAME;
      pos_q     <= '0;
      match_a_q <= 1'b1;
      match_b_q <= 1'b1;
    end else if (step_i) begin
      if (last_i) begin
        count_q   <= '0;
        opcode_q  <= '0;
        err_q     <= '0;
        phase_q   <= PH_NAME;
        pos_q     <= '0;
        match_a_q <= 1'b1;
        match_b_q <= 1'b1;
      end else begin
        count_q   <= count_d;
        opcode_q  <= opcode_d;
        err_q     <= err_d;
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        match_a_q <= match_a_d;
        match_b_q <= match_b_d;
      end
    end
  end

endmodule

FILE: design/tpc_checker.sv
// tpc_checker: port-level assertions on the tftp packet checker, bound to the top
// depends on tpc_pkg and tftp_packet_checker_top
module tpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [15:0] opcode_o
);
  import tpc_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(opcode_o))
    else $error("stalled result changed");

  // status stays within its codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_UNKNOWN_OP)
    else $error("status code out of range");

  // an accepted packet carries a known opcode
  a_ok_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> opcode_o >= OP_RRQ && opcode_o <= OP_ERROR)
    else $error("ok status with unknown opcode");

  // unknown opcode status never names a known opcode
  a_unknown_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNKNOWN_OP |-> opcode_o < OP_RRQ || opcode_o > OP_ERROR)
    else $error("unknown opcode status with known opcode");

  // bad mode only for read and write requests
  a_bad_mode_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_MODE |-> opcode_o == OP_RRQ || opcode_o == OP_WRQ)
    else $error("bad mode status outside a request");

endmodule

bind tftp_packet_checker_top tpc_checker u_tpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .opcode_o    (opcode_o)
);

FILE: tb/sv/tpc_verdict_pkg.sv
// tpc_verdict_pkg: predictor and scoreboard for the tftp packet checker bench
// depends on tpc_pkg for the status codes, opcodes, register indexes and sizes
package tpc_verdict_pkg;

  import tpc_pkg::*;

  // one expected status word
  typedef struct packed {
    status_e     status;
    logic [15:0] opcode;
  } verdict_t;

  // where a read or write request is in its strings
  typedef enum logic [1:0] {
    IN_NAME   = 2'd0,
    IN_MODE   = 2'd1,
    MODE_DONE = 2'd2
  } req_phase_e;

  class verdict_board;
    // mode registers as the block should hold them
    logic [CFG_DATA_W-1:0] text_a;
    logic [CFG_DATA_W-1:0] text_b;
    logic [POS_W-1:0]      len_a;
    logic [POS_W-1:0]      len_b;

    // state of the packet being received
    logic [COUNT_W-1:0]    byte_cnt;
    logic [15:0]           op_word;
    logic [15:0]           err_word;
    req_phase_e            phase;
    logic [POS_W-1:0]      pos;
    bit                    a_ok;
    bit                    b_ok;

    verdict_t              verdicts_due[$];
    int unsigned           faults;
    int unsigned           checked;

    function new();
      text_a  = '0;
      text_b  = '0;
      len_a   = '0;
      len_b   = '0;
      faults  = 0;
      checked = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_cnt = '0;
      op_word  = '0;
      err_word = '0;
      phase    = IN_NAME;
      pos      = '0;
      a_ok     = 1'b1;
      b_ok     = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE_A_TEXT: text_a = data;
        CFG_MODE_A_LEN:  len_a  = data[POS_W-1:0];
        CFG_MODE_B_TEXT: text_b = data;
        CFG_MODE_B_LEN:  len_b  = data[POS_W-1:0];
        default: ;
      endcase
    endfunction

    // does the mode character at the current position equal ch
    function bit char_hit(logic [CFG_DATA_W-1:0] text, logic [POS_W-1:0] len,
                          logic [7:0] ch);
      if (pos >= MODE_CHARS || pos >= len) return 1'b0;
      return text[8*pos +: 8] == ch;
    endfunction

    function status_e judge();
      if (byte_cnt < 2) return ST_TOO_SHORT;
      if (byte_cnt > MAX_PACKET_BYTES) return ST_TOO_LONG;
      case (op_word)
        OP_RRQ, OP_WRQ: begin
          if (byte_cnt < 4) return ST_TOO_SHORT;
          // unterminated filename or mode counts as a bad mode
          if (phase != MODE_DONE) return ST_BAD_MODE;
          if (!a_ok && !b_ok) return ST_BAD_MODE;
          return ST_OK;
        end
        OP_DATA: return (byte_cnt < 4) ? ST_TOO_SHORT : ST_OK;
        OP_ACK: begin
          if (byte_cnt < 4) return ST_TOO_SHORT;
          if (byte_cnt > 4) return ST_TOO_LONG;
          return ST_OK;
        end
        OP_ERROR: begin
          if (byte_cnt < 5) return ST_TOO_SHORT;
          if (err_word >= ERR_CODE_LIMIT) return ST_BAD_ERROR;
          return ST_OK;
        end
        default: return ST_UNKNOWN_OP;
      endcase
    endfunction

    // note one accepted byte; the last byte of a packet queues a verdict
    function void take_byte(logic [7:0] b, bit lst);
      verdict_t v;
      if (byte_cnt < 2) begin
        op_word = {op_word[7:0], b};
      end else begin
        if (byte_cnt < 4) err_word = {err_word[7:0], b};
        case (phase)
          IN_NAME: begin
            if (b == 8'h00) begin
              phase = IN_MODE;
              pos   = '0;
            end
          end
          IN_MODE: begin
            if (b == 8'h00) begin
              if (pos != len_a || len_a > MODE_CHARS) a_ok = 1'b0;
              if (pos != len_b || len_b > MODE_CHARS) b_ok = 1'b0;
              phase = MODE_DONE;
            end else begin
              if (!char_hit(text_a, len_a, b)) a_ok = 1'b0;
              if (!char_hit(text_b, len_b, b)) b_ok = 1'b0;
              if (pos != '1) pos = pos + 1'b1;
            end
          end
          default: ;
        endcase
      end
      // byte counter saturates
      if (byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
      if (lst) begin
        v.status = judge();
        v.opcode = (byte_cnt >= 2) ? op_word : 16'h0000;
        verdicts_due.push_back(v);
        clear_packet();
      end
    endfunction

    function int unsigned due();
      return verdicts_due.size();
    endfunction

    // compare one accepted status word with the oldest verdict
    function void check_verdict(logic [2:0] st, logic [15:0] opc);
      verdict_t want;
      checked++;
      if (verdicts_due.size() == 0) begin
        $display("%0t: status word with none due: status %0d opcode %h",
                 $time, st, opc);
        faults++;
        return;
      end
      want = verdicts_due.pop_front();
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, st);
        faults++;
      end
      if (opc !== want.opcode) begin
        $display("%0t: opcode mismatch: expected %h actual %h",
                 $time, want.opcode, opc);
        faults++;
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
// tb: top of the tftp packet checker bench; sends packets byte by byte,
// programs the mode registers and checks every status word
// depends on tpc_pkg, tpc_verdict_pkg and tftp_packet_checker_top
module tb;

  import tpc_pkg::*;
  import tpc_verdict_pkg::*;

  localparam int unsigned LATENCY      = 2;
  localparam int unsigned PHASE_BYTES  = 40;
  localparam int unsigned NUM_SETTINGS = 6;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  last_i      = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [2:0]            status_o;
  logic [15:0]           opcode_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned           cycles      = 0;
  int unsigned           packets     = 0;
  int unsigned           bytes_sent  = 0;
  bit                    quiet       = 1'b0;
  logic [2:0]            hold        = '0;
  logic [7:0]            pkt[$];
  logic [CFG_DATA_W-1:0] mode_text[2];
  logic [POS_W-1:0]      mode_len[2];
  verdict_board          board;

  tftp_packet_checker_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .opcode_o    (opcode_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  // result side: check each word, then stall for a random count
  always @(posedge clk_i) begin : result_side
    int unsigned n;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_verdict(status_o, opcode_o);
        n = quiet ? 0 : $urandom_range(0, 4);
        hold        <= n[2:0];
        out_stall_i <= (n != 0);
      end else if (hold > 1) begin
        hold        <= hold - 1'b1;
        out_stall_i <= 1'b1;
      end else begin
        hold        <= '0;
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("simulation failed");
    $finish;
  end

  // one byte word, after a random gap
  task automatic send_byte(input logic [7:0] b, input bit lst);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_byte(b, lst);
    bytes_sent++;
  endtask

  // wait until every verdict has come back and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.due() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_packet();
    quiet = ($urandom_range(0, 4) == 0);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    packets++;
    // now and then hold the sender until all results are in
    if ($urandom_range(0, 49) == 0) settle();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  // mode strings, first character in the lowest byte
  task automatic program_setting(input int unsigned ph);
    logic [CFG_DATA_W-1:0] ta, tb_text, junk;
    logic [POS_W-1:0]      la, lb;
    case (ph)
      0: begin  // "octet" and "netascii"
        ta = 64'h0000_0074_6574_636f;  la = 4'd5;
        tb_text = 64'h6969_6373_6174_656e;  lb = 4'd8;
      end
      1: begin  // full length mode and one too long to ever match
        ta = {$urandom, $urandom};  la = 4'd8;
        tb_text = {$urandom, $urandom};  lb = 4'($urandom_range(9, 15));
      end
      2: begin  // zero inside a mode, and "mail"
        ta = 64'h0000_0000_6c00_616d;  la = 4'd4;
        tb_text = 64'h0000_0000_6c69_616d;  lb = 4'd4;
      end
      3: begin  // all ones text, and an empty mode
        ta = '1;  la = 4'd8;
        tb_text = '0;  lb = 4'd0;
      end
      4: begin
        ta = {$urandom, $urandom};  la = 4'($urandom_range(0, 15));
        tb_text = {$urandom, $urandom};  lb = 4'($urandom_range(0, 8));
      end
      default: begin  // "octet" and "OCTET"
        ta = 64'h0000_0074_6574_636f;  la = 4'd5;
        tb_text = 64'h0000_0054_4554_434f;  lb = 4'd5;
      end
    endcase
    junk = {$urandom, $urandom};
    write_reg(CFG_MODE_A_TEXT, ta);
    write_reg(CFG_MODE_A_LEN, {junk[CFG_DATA_W-1:POS_W], la});
    junk = {$urandom, $urandom};
    write_reg(CFG_MODE_B_TEXT, tb_text);
    write_reg(CFG_MODE_B_LEN, {junk[CFG_DATA_W-1:POS_W], lb});
    cfg_we_i <= 1'b0;
    mode_text[0] = ta;
    mode_text[1] = tb_text;
    mode_len[0]  = la;
    mode_len[1]  = lb;
    @(posedge clk_i);
  endtask

  // random packet, mostly well formed
  task automatic build_packet();
    int unsigned kind, n, m, sel, nm;
    logic [15:0] code;
    pkt.delete();
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // read or write request
      pkt.push_back(OP_RRQ[15:8]);
      pkt.push_back($urandom_range(0, 1) ? OP_WRQ[7:0] : OP_RRQ[7:0]);
      n = $urandom_range(0, 5);
      repeat (n) pkt.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 9) != 0) begin
        pkt.push_back(8'h00);
        m   = $urandom_range(0, 1);
        nm  = (mode_len[m] > MODE_CHARS) ? MODE_CHARS : mode_len[m];
        sel = $urandom_range(0, 5);
        if (sel == 4 && nm != 0) nm--;
        if (sel == 5) begin
          n = $urandom_range(0, 9);
          repeat (n) pkt.push_back(8'($urandom_range(1, 255)));
        end else begin
          for (int i = 0; i < nm; i++) pkt.push_back(mode_text[m][8*i +: 8]);
        end
        // one character off
        if (sel == 2 && nm != 0)
          pkt[pkt.size() - 1 - $urandom_range(0, nm - 1)] = 8'($urandom_range(1, 255));
        if (sel == 3) pkt.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 6) != 0) begin
          pkt.push_back(8'h00);
          n = $urandom_range(0, 3);
          repeat (n) pkt.push_back(8'($urandom));
        end
      end
    end else if (kind < 60) begin
      pkt.push_back(OP_DATA[15:8]);
      pkt.push_back(OP_DATA[7:0]);
      n = $urandom_range(0, 12);
      repeat (n) pkt.push_back(8'($urandom));
    end else if (kind < 70) begin
      pkt.push_back(OP_ACK[15:8]);
      pkt.push_back(OP_ACK[7:0]);
      n = $urandom_range(0, 4);
      repeat (n) pkt.push_back(8'($urandom));
    end else if (kind < 82) begin
      pkt.push_back(OP_ERROR[15:8]);
      pkt.push_back(OP_ERROR[7:0]);
      n = $urandom_range(0, 9);
      if (n < 3) begin
        repeat (n) pkt.push_back(8'($urandom));
      end else begin
        code = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        pkt.push_back(code[15:8]);
        pkt.push_back(code[7:0]);
        n = $urandom_range(0, 4);
        repeat (n) pkt.push_back(8'($urandom_range(1, 255)));
        pkt.push_back(8'h00);
      end
    end else if (kind < 90) begin
      code = 16'($urandom);
      pkt.push_back(code[15:8]);
      pkt.push_back(code[7:0]);
      n = $urandom_range(0, 4);
      repeat (n) pkt.push_back(8'($urandom));
    end else if (kind < 95) begin
      pkt.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) pkt.push_back(8'($urandom));
    end
  endtask

  // packet of a given length with nonzero payload
  task automatic send_long(input logic [15:0] op, input int unsigned len);
    pkt.delete();
    pkt.push_back(op[15:8]);
    pkt.push_back(op[7:0]);
    repeat (len - 2) pkt.push_back(8'($urandom_range(1, 255)));
    send_packet();
  endtask

  // main sequence
  initial begin : main_seq
    int unsigned start;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed packets with the mode registers at reset
    pkt = '{8'hFF};
    send_packet();
    pkt = '{OP_RRQ[15:8], OP_RRQ[7:0]};
    send_packet();
    pkt = '{OP_RRQ[15:8], OP_RRQ[7:0], 8'h00, 8'h00};
    send_packet();
    pkt = '{OP_WRQ[15:8], OP_WRQ[7:0], 8'h41, 8'h42};
    send_packet();
    pkt = '{OP_ACK[15:8], OP_ACK[7:0], 8'h12, 8'h34};
    send_packet();
    pkt = '{OP_DATA[15:8], OP_DATA[7:0], 8'hFF};
    send_packet();
    pkt = '{OP_ERROR[15:8], OP_ERROR[7:0], ERR_CODE_LIMIT[15:8], ERR_CODE_LIMIT[7:0],
            8'h00};
    send_packet();
    pkt = '{8'hFF, 8'hFF};
    send_packet();

    // random packets under each mode setting
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      settle();
      program_setting(ph);
      if (ph == 2) begin
        // longest legal packet, and one just past the counter range
        send_long(OP_DATA, MAX_PACKET_BYTES);
        send_long(OP_RRQ, 1025);
      end
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        build_packet();
        send_packet();
      end
    end

    settle();
    $display("%0d packets, %0d bytes, reset modes and %0d programmed mode settings",
             packets, bytes_sent, NUM_SETTINGS);
    $display("%0d status words checked, %0d mismatches", board.checked, board.faults);
    if (board.faults == 0 && board.due() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
